[src/rlss_pkg.sv]
// Shared types and constants for the rotation LED sequencer with speed control.
package rlss_pkg;

  // Field and register widths.
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BTN_W       = 6;
  localparam int unsigned LED_W       = 6;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned SPEED_W     = 2;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned CFG_INDEX_W = 2;

  // Number of speed levels; the top level is capped by the number of period registers.
  localparam int unsigned SPEED_LEVELS = 4;
  localparam int unsigned LEVEL_CAP    = (SPEED_LEVELS > NUM_REGS) ? NUM_REGS : SPEED_LEVELS;
  localparam logic [SPEED_W-1:0] TOP_LEVEL = SPEED_W'(LEVEL_CAP - 1);

  // Saturation value of the tick and second counters.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Event kinds carried in tuser.
  localparam logic [OP_W-1:0] OP_PINS   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_SECOND = 2'd2;

  // Mode codes, also reported on the result channel.
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  // Button masks as they appear in the press latch.
  localparam logic [BTN_W-1:0] BTN_RESET  = 6'h01;
  localparam logic [BTN_W-1:0] BTN_FASTER = 6'h04;
  localparam logic [BTN_W-1:0] BTN_SLOWER = 6'h08;
  localparam logic [BTN_W-1:0] BTN_FLIP   = 6'h20;

  // LED masks.
  localparam logic [LED_W-1:0] LED_ONE   = 6'h02;
  localparam logic [LED_W-1:0] LED_TWO   = 6'h04;
  localparam logic [LED_W-1:0] LED_THREE = 6'h08;
  localparam logic [LED_W-1:0] LED_FIVE  = 6'h20;
  localparam logic [LED_W-1:0] LED_RING  = LED_ONE | LED_TWO | LED_THREE;

  // Division by three as multiply by ceil(2^17 / 3) and shift; exact for 16-bit values.
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 17'h0AAAB;

  typedef logic [PERIOD_W-1:0] period_t;

  // Period of the selected level and its phase length (period / 3).
  typedef struct packed {
    period_t period;
    period_t phase;
  } period_sel_t;

  // Reset contents of the period registers and their precomputed thirds.
  localparam period_t PERIOD_RESET [NUM_REGS] = '{16'd900, 16'd750, 16'd600, 16'd300};
  localparam period_t PHASE_RESET  [NUM_REGS] = '{16'd300, 16'd250, 16'd200, 16'd100};

endpackage

[src/rotation_led_sequencer_speed_control_top.sv]
// Top level of the rotation LED sequencer: event intake, mode machine and result channel.
// An accepted item passes the input register, then the state registers, before its result is valid.
// Throughput: one item per cycle while out_tready does not stall; the mode machine finishes each item in one step.
// The state registers double as the result register, so the result holds while it stalls.
// Reset (rst_n low, synchronous): idle mode, all counters, latch and LEDs cleared,
// period registers back to 900, 750, 600 and 300 ticks.
module rotation_led_sequencer_speed_control_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [5:0] pins
  input  logic [1:0]                       in_tuser,   // [1:0] op
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,  // [5:0] led_port, [7:6] mode,
                                                       // [9:8] speed_level, [10] clockwise
  // Configuration port.
  input  logic                             cfg_we,
  input  logic [rlss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rlss_pkg::PERIOD_W-1:0]    cfg_wdata
);

  // Input register.
  logic                          s1_valid_r;
  logic [rlss_pkg::OP_W-1:0]     s1_op_r;
  logic [rlss_pkg::BTN_W-1:0]    s1_pins_r;

  logic out_valid_r;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  // Block state.
  logic [rlss_pkg::MODE_W-1:0]  mode_r,   mode_nxt;
  logic [rlss_pkg::BTN_W-1:0]   latch_r,  latch_nxt;
  logic [rlss_pkg::BTN_W-1:0]   prev_r,   prev_nxt;
  logic [rlss_pkg::CNT_W-1:0]   sec_r,    sec_nxt;
  logic [rlss_pkg::CNT_W-1:0]   tick_r,   tick_nxt;
  logic [rlss_pkg::SPEED_W-1:0] speed_r,  speed_nxt;
  logic                         dir_r,    dir_nxt;
  logic [rlss_pkg::LED_W-1:0]   led_r,    led_nxt;

  // State after the event, before the mode machine step.
  logic [rlss_pkg::BTN_W-1:0]   fall;
  logic [rlss_pkg::BTN_W-1:0]   ev_latch;
  logic [rlss_pkg::CNT_W-1:0]   ev_tick;
  logic [rlss_pkg::CNT_W-1:0]   ev_sec;
  logic [rlss_pkg::LED_W-1:0]   ring_on;
  logic [rlss_pkg::PERIOD_W:0]  two_phase;

  rlss_pkg::period_sel_t sel;

  rlss_period_bank u_period_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .level     (speed_r),
    .sel       (sel)
  );

  // Handshake: the input register moves on whenever the result slot is free or being taken.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_tuser;
      s1_pins_r <= in_tdata[rlss_pkg::BTN_W-1:0];
    end
  end

  // Event update: edge detection on pin samples, saturating tick and second counters.
  always_comb begin
    fall     = '0;
    prev_nxt = prev_r;
    ev_latch = latch_r;
    ev_tick  = tick_r;
    ev_sec   = sec_r;
    case (s1_op_r)
      rlss_pkg::OP_PINS: begin
        fall     = (prev_r ^ s1_pins_r) & ~s1_pins_r;
        prev_nxt = s1_pins_r;
        // The highest-numbered falling button wins.
        for (int i = 0; i < rlss_pkg::BTN_W; i++) begin
          if (fall[i]) begin
            ev_latch = rlss_pkg::BTN_W'(1) << i;
          end
        end
      end
      rlss_pkg::OP_TICK: begin
        if (tick_r != rlss_pkg::CNT_MAX) begin
          ev_tick = tick_r + 1'b1;
        end
      end
      rlss_pkg::OP_SECOND: begin
        if (sec_r != rlss_pkg::CNT_MAX) begin
          ev_sec = sec_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Which ring LED is lit for the current tick count.
  assign two_phase = {1'b0, sel.phase} << 1;

  always_comb begin
    if (ev_tick <= sel.phase) begin
      ring_on = dir_r ? rlss_pkg::LED_ONE : rlss_pkg::LED_THREE;
    end else if ({1'b0, ev_tick} <= two_phase) begin
      ring_on = rlss_pkg::LED_TWO;
    end else begin
      ring_on = dir_r ? rlss_pkg::LED_THREE : rlss_pkg::LED_ONE;
    end
  end

  // Mode machine: one step per item.
  always_comb begin
    mode_nxt  = mode_r;
    latch_nxt = ev_latch;
    tick_nxt  = ev_tick;
    sec_nxt   = ev_sec;
    speed_nxt = speed_r;
    dir_nxt   = dir_r;
    led_nxt   = led_r;
    case (mode_r)
      rlss_pkg::MODE_IDLE: begin
        led_nxt = led_r | rlss_pkg::LED_FIVE;
        if (ev_latch == rlss_pkg::BTN_FASTER || ev_latch == rlss_pkg::BTN_SLOWER) begin
          mode_nxt = rlss_pkg::MODE_ROT;
        end
      end
      rlss_pkg::MODE_ROT: begin
        led_nxt = (led_r & ~rlss_pkg::LED_RING) | ring_on;
        if (ev_tick >= sel.period) begin
          tick_nxt = '0;
        end
        // Speed changes and the direction flip wait for a full second each time.
        if (ev_latch == rlss_pkg::BTN_FASTER) begin
          if (ev_sec != '0) begin
            if (speed_r < rlss_pkg::TOP_LEVEL) begin
              speed_nxt = speed_r + 1'b1;
            end
            sec_nxt = '0;
          end
        end else if (ev_latch == rlss_pkg::BTN_SLOWER) begin
          if (ev_sec != '0) begin
            if (speed_r != '0) begin
              speed_nxt = speed_r - 1'b1;
            end
            sec_nxt = '0;
          end
        end
        if (ev_latch == rlss_pkg::BTN_FLIP) begin
          if (ev_sec != '0) begin
            dir_nxt = ~dir_r;
            sec_nxt = '0;
          end
          latch_nxt = '0;
        end
        if (ev_latch == rlss_pkg::BTN_RESET) begin
          mode_nxt = rlss_pkg::MODE_RESET;
        end
      end
      default: begin
        // Resetting: clear LEDs, counters and the latch, then go back to idle.
        led_nxt   = '0;
        tick_nxt  = '0;
        sec_nxt   = '0;
        latch_nxt = '0;
        mode_nxt  = rlss_pkg::MODE_IDLE;
      end
    endcase
  end

  // State registers; they change only when an item moves into the result slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rlss_pkg::MODE_IDLE;
      latch_r <= '0;
      prev_r  <= '1;
      sec_r   <= '0;
      tick_r  <= '0;
      speed_r <= '0;
      dir_r   <= 1'b0;
      led_r   <= '0;
    end else if (s1_adv) begin
      mode_r  <= mode_nxt;
      latch_r <= latch_nxt;
      prev_r  <= prev_nxt;
      sec_r   <= sec_nxt;
      tick_r  <= tick_nxt;
      speed_r <= speed_nxt;
      dir_r   <= dir_nxt;
      led_r   <= led_nxt;
    end
  end

  // Result channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, dir_r, speed_r, mode_r, led_r};

  // A resetting step always returns to idle with all LEDs dark.
  a_reset_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && mode_r == rlss_pkg::MODE_RESET |=> led_r == '0 && mode_r == rlss_pkg::MODE_IDLE)
    else $error("resetting step did not clear LEDs and return to idle");

  // After a rotation step exactly one ring LED is lit.
  a_ring_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && mode_r == rlss_pkg::MODE_ROT |=> $onehot(led_r[3:1]))
    else $error("ring LEDs not one-hot after rotation step");

  // The speed level never passes the top level.
  a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= rlss_pkg::TOP_LEVEL)
    else $error("speed level above top level");

  // State only moves when an item advances into the result slot.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(mode_r) && $stable(speed_r) && $stable(led_r) && $stable(dir_r))
    else $error("state changed without an item");

endmodule

[src/rlss_period_bank.sv]
// Period registers per speed level, with the phase length computed at write time.
module rlss_period_bank (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rlss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rlss_pkg::PERIOD_W-1:0]    cfg_wdata,
  input  logic [rlss_pkg::SPEED_W-1:0]     level,
  output rlss_pkg::period_sel_t            sel
);

  localparam int unsigned PROD_W = rlss_pkg::PERIOD_W + rlss_pkg::RECIP_W;

  rlss_pkg::period_t period_r [rlss_pkg::NUM_REGS];
  rlss_pkg::period_t phase_r  [rlss_pkg::NUM_REGS];

  logic [PROD_W-1:0]  third_prod;
  rlss_pkg::period_t  phase_nxt;

  // One third of the written value, by reciprocal multiplication.
  assign third_prod = PROD_W'(cfg_wdata) * PROD_W'(rlss_pkg::RECIP_THIRD);
  assign phase_nxt  = third_prod[rlss_pkg::RECIP_SHIFT +: rlss_pkg::PERIOD_W];

  // Register writes; the phase is stored alongside the period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rlss_pkg::NUM_REGS; i++) begin
        period_r[i] <= rlss_pkg::PERIOD_RESET[i];
        phase_r[i]  <= rlss_pkg::PHASE_RESET[i];
      end
    end else if (cfg_we) begin
      period_r[cfg_index] <= cfg_wdata;
      phase_r[cfg_index]  <= phase_nxt;
    end
  end

  // Values for the current speed level.
  assign sel.period = period_r[level];
  assign sel.phase  = phase_r[level];

endmodule
